// File: hdl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list insert/remove block.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int COUNT_FIELD_W = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic                      operation;
      logic signed [VALUE_W-1:0] item_value;
   } req_word_type;

   typedef struct packed {
      status_type                 status;
      logic [COUNT_FIELD_W-1:0]   entry_count;
   } rsp_word_type;

   // Broadcast to every cell
   typedef struct packed {
      logic                      insert_en;
      logic                      remove_en;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

   // Per-cell compare results
   typedef struct packed {
      logic open;   // empty or entry > value
      logic ge;     // empty or entry >= value
      logic eq;     // occupied and entry == value
   } cell_flag_type;

endpackage

// File: hdl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast value and loads that value or shifts from its left or right neighbor.
// ----------------------------------------------------------------------------
module sli_cell import sli_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic signed [VALUE_W-1:0] right_entry,
   input  logic                      left_open,
   input  logic                      found,
   output logic signed [VALUE_W-1:0] entry,
   output cell_flag_type             flags
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      occupied;

   assign occupied   = count > CNT_W'(INDEX);
   assign flags.open = !occupied || (entry_ff > ctrl.value);
   assign flags.ge   = !occupied || (entry_ff >= ctrl.value);
   assign flags.eq   = occupied && (entry_ff == ctrl.value);
   assign entry      = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (left_open) begin
            entry_in = left_entry;
         end else if (flags.open) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.remove_en && found && flags.ge) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/sorted_list_insert_remove.sv
// The result word is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while req_stall is low; every cell compares and shifts in that same cycle.
// Input stalls only while a result word is held by a stalled output.
// Reset clears the entry count and output valid; stored entries stay undefined until written.
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// Sorted store of signed values built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove import sli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   rsp_word_type              rsp_word_ff;
   status_type                status_in;
   logic                      accept;
   logic                      full;
   logic                      found;
   cell_ctrl_type             ctrl;
   cell_flag_type             flags [DEPTH];
   logic signed [VALUE_W-1:0] entries [DEPTH];
   logic [DEPTH-1:0]          eq_vec;
   logic [CNT_W+COUNT_FIELD_W-1:0] count_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign found     = |eq_vec;

   assign ctrl.insert_en = accept && (req_word.operation == OP_INSERT) && !full;
   assign ctrl.remove_en = accept && (req_word.operation == OP_REMOVE);
   assign ctrl.value     = req_word.item_value;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [VALUE_W-1:0] left_e;
         logic signed [VALUE_W-1:0] right_e;
         logic                      left_o;
         if (gi == 0) begin : g_first
            assign left_e = req_word.item_value;
            assign left_o = 1'b0;
         end else begin : g_mid
            assign left_e = entries[gi-1];
            assign left_o = flags[gi-1].open;
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_e = entries[gi];
         end else begin : g_body
            assign right_e = entries[gi+1];
         end
         assign eq_vec[gi] = flags[gi].eq;

         sli_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .count       (count_ff),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_open   (left_o),
            .found       (found),
            .entry       (entries[gi]),
            .flags       (flags[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = ST_INSERTED;
      if (req_word.operation == OP_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
            count_in  = count_ff + CNT_W'(1);
         end
      end else begin
         if (found) begin
            status_in = ST_REMOVED;
            count_in  = count_ff - CNT_W'(1);
         end else begin
            status_in = ST_NOT_FOUND;
         end
      end
   end

   assign count_ext = {{COUNT_FIELD_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff.status      <= status_in;
         rsp_word_ff.entry_count <= count_ext[COUNT_FIELD_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");

   a_miss_keeps: assert property (@(posedge clock) disable iff (reset)
      (ctrl.remove_en && !found) |=> $stable(count_ff))
      else $error("missed remove changed count");

   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.operation == OP_INSERT && full)
         |=> (rsp_word.status == ST_FULL) && $stable(count_ff))
      else $error("insert into full store not dropped");

endmodule
